@@ rtl/irrigation_sequencer_unit_assert.svh @@
// Assertion macros for the irrigation sequencer.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef IRRIGATION_SEQUENCER_UNIT_ASSERT_SVH
`define IRRIGATION_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define IRSEQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("irrigation sequencer: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define IRSEQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("irrigation sequencer: next-cycle check failed");

`endif

@@ rtl/irseq_pkg.sv @@
`timescale 1ns / 1ps

package irseq_pkg;

    // Field widths
    localparam int TICK_W  = 32;
    localparam int HUM_W   = 7;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Phase codes
    localparam logic [PHASE_W-1:0] PHASE_WAIT    = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_MEASURE = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_WATER   = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_ALARM   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WATER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_THRESH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_THRESH   = 3'd4;

    // Reset values of the configuration registers
    localparam logic [TICK_W-1:0] RST_WAIT_TICKS   = 32'd1000;
    localparam logic [TICK_W-1:0] RST_SETTLE_TICKS = 32'd100;
    localparam logic [TICK_W-1:0] RST_MAX_WATER    = 32'd10000;
    localparam logic [HUM_W-1:0]  RST_DRY_THRESH   = 7'd30;
    localparam logic [HUM_W-1:0]  RST_WET_THRESH   = 7'd60;

    typedef struct packed {
        logic [TICK_W-1:0] wait_ticks;
        logic [TICK_W-1:0] settle_ticks;
        logic [TICK_W-1:0] max_water_ticks;
        logic [HUM_W-1:0]  dry_threshold;
        logic [HUM_W-1:0]  wet_threshold;
    } t_cfg;

    // Levels and phase after one step
    typedef struct packed {
        logic               valve_on;
        logic               alarm_on;
        logic [PHASE_W-1:0] phase;
    } t_result;

endpackage

@@ rtl/irseq_cfg_regs.sv @@
`timescale 1ns / 1ps

module irseq_cfg_regs
    import irseq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Always able to take a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Write the addressed register, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wait_ticks      <= RST_WAIT_TICKS;
            r_cfg.settle_ticks    <= RST_SETTLE_TICKS;
            r_cfg.max_water_ticks <= RST_MAX_WATER;
            r_cfg.dry_threshold   <= RST_DRY_THRESH;
            r_cfg.wet_threshold   <= RST_WET_THRESH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WAIT_TICKS:   r_cfg.wait_ticks      <= i_cfg_data[TICK_W-1:0];
                CFG_SETTLE_TICKS: r_cfg.settle_ticks    <= i_cfg_data[TICK_W-1:0];
                CFG_MAX_WATER:    r_cfg.max_water_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_DRY_THRESH:   r_cfg.dry_threshold   <= i_cfg_data[HUM_W-1:0];
                CFG_WET_THRESH:   r_cfg.wet_threshold   <= i_cfg_data[HUM_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/irseq_step.sv @@
`timescale 1ns / 1ps

module irseq_step
    import irseq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_cfg             i_cfg,
    input  logic             i_tick,
    input  logic [HUM_W-1:0] i_humidity,
    output t_result          o_result
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [TICK_W-1:0]  r_ticks, n_ticks;
    logic               r_watered, n_watered;
    logic               r_valve, n_valve;
    logic               r_alarm, n_alarm;
    logic [TICK_W-1:0]  ticks_now;
    logic               dry, wet;

    // Saturating tick count, then compare against the phase times
    assign ticks_now = (i_tick && (r_ticks != {TICK_W{1'b1}})) ? r_ticks + 1'b1 : r_ticks;
    assign dry       = i_humidity <  i_cfg.dry_threshold;
    assign wet       = i_humidity >= i_cfg.wet_threshold;

    // Next phase and levels for this item
    always_comb begin
        n_phase   = r_phase;
        n_ticks   = ticks_now;
        n_watered = r_watered;
        n_valve   = r_valve;
        n_alarm   = r_alarm;
        case (r_phase)
            PHASE_WAIT: begin
                if (ticks_now >= i_cfg.wait_ticks) begin
                    n_phase = PHASE_MEASURE;
                    n_ticks = '0;
                end
            end
            PHASE_MEASURE: begin
                if (ticks_now >= i_cfg.settle_ticks) begin
                    n_ticks = '0;
                    if (dry) begin
                        if (r_watered) begin
                            n_phase = PHASE_ALARM;
                        end else begin
                            n_valve = 1'b1;
                            n_phase = PHASE_WATER;
                        end
                    end else begin
                        n_alarm   = 1'b0;
                        n_watered = 1'b0;
                        n_phase   = PHASE_WAIT;
                    end
                end
            end
            PHASE_WATER: begin
                if (wet || (ticks_now >= i_cfg.max_water_ticks)) begin
                    n_valve   = 1'b0;
                    n_watered = 1'b1;
                    n_phase   = PHASE_WAIT;
                    n_ticks   = '0;
                end
            end
            default: begin
                n_alarm   = 1'b1;
                n_watered = 1'b0;
                n_phase   = PHASE_WAIT;
                n_ticks   = '0;
            end
        endcase
    end

    assign o_result.valve_on = n_valve;
    assign o_result.alarm_on = n_alarm;
    assign o_result.phase    = n_phase;

    // Advance state only when an item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PHASE_WAIT;
            r_ticks   <= '0;
            r_watered <= 1'b0;
            r_valve   <= 1'b0;
            r_alarm   <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_ticks   <= n_ticks;
            r_watered <= n_watered;
            r_valve   <= n_valve;
            r_alarm   <= n_alarm;
        end
    end

endmodule

@@ rtl/irrigation_sequencer_unit.sv @@
`timescale 1ns / 1ps
// Irrigation sequencer: wait / measure / water / alarm controller.
// Input stream (s side): one item per poll, tdata = tick_passed, humidity.
// Output stream (m side): one item per input item, tdata = valve_on,
//   alarm_on, phase, the levels and phase after that poll.
// Config channel: index 0..4 selects wait_ticks, settle_ticks,
//   max_water_ticks, dry_threshold, wet_threshold; other indexes are dropped.
//   Write only while no items are in flight; o_cfg_ready is always high.
// Path: an accepted item goes through the input register, then the step
//   logic into the output register before it shows on the m side.
// Throughput: one item per cycle while the receiver does not stall, set by
//   the single compare-and-count step between the input and output registers.
// Receiver stall: the output register holds its item, the input register
//   takes one more item, then s_tready drops until the output drains.
// Reset (synchronous, active low): phase wait, tick count zero, valve and
//   alarm off, both registers empty, configuration back to its defaults.

`include "irrigation_sequencer_unit_assert.svh"

module irrigation_sequencer_unit
    import irseq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [0] tick_passed, [7:1] humidity
    // result items
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // [0] valve_on, [1] alarm_on, [3:2] phase, [7:4] 0
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg             cfg;
    t_result          step_res;
    logic             r_in_valid;
    logic             r_in_tick;
    logic [HUM_W-1:0] r_in_hum;
    logic             r_out_valid;
    t_result          r_out;
    logic             out_free;
    logic             step;

    irseq_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Handshake between input register and output register
    assign out_free   = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    irseq_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_cfg      (cfg),
        .i_tick     (r_in_tick),
        .i_humidity (r_in_hum),
        .o_result   (step_res)
    );

    // Input register: load on accept, empty when the step consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_tick <= i_s_tdata[0];
            r_in_hum  <= i_s_tdata[7:1];
        end
    end

    // Output register: load on step, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out.phase, r_out.alarm_on, r_out.valve_on};

    // Valve is open exactly in the watering phase
    `IRSEQ_ASSERT_NOW(a_valve_phase, r_out_valid, r_out.valve_on == (r_out.phase == PHASE_WATER))
    // Both registers full and receiver stalled: no new item
    `IRSEQ_ASSERT_NOW(a_full_stall, r_in_valid && r_out_valid && !i_m_tready, !o_s_tready)
    // A processed item shows up as a result in the next cycle
    `IRSEQ_ASSERT_NEXT(a_step_out, step, r_out_valid)

endmodule

@@ bench/irrigation_sequencer_unit_checker.sv @@
`timescale 1ns / 1ps

// Watches the three channels of the irrigation sequencer, predicts the valve,
// alarm and phase after every accepted poll and compares each result item.
module irrigation_sequencer_unit_checker
    import irseq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [7:0]            i_s_tdata,   // [0] tick_passed, [7:1] humidity
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [7:0]            i_m_tdata,   // [0] valve_on, [1] alarm_on, [3:2] phase
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_fail_count
);

    // Shadow copy of the registers and of the controller state
    t_cfg               cfg_regs;
    logic [PHASE_W-1:0] phase_now;
    logic [TICK_W-1:0]  phase_ticks;
    logic               retry_mark;
    logic               valve_q;
    logic               alarm_q;

    t_result expected_levels[$];
    int      fails;
    int      checked;

    initial begin
        o_pending    = 0;
        o_checked    = 0;
        o_fail_count = 0;
        fails        = 0;
        checked      = 0;
    end

    // Clear the tick count on every phase change
    task automatic switch_phase(input logic [PHASE_W-1:0] next_phase);
        phase_now   = next_phase;
        phase_ticks = '0;
    endtask

    // Advance the controller by one poll and return the levels after it
    task automatic advance_controller(input logic tick, input logic [HUM_W-1:0] hum,
                                      output t_result res);
        if (tick && phase_ticks != '1)
            phase_ticks = phase_ticks + 1'b1;
        case (phase_now)
            PHASE_WAIT: begin
                if (phase_ticks >= cfg_regs.wait_ticks)
                    switch_phase(PHASE_MEASURE);
            end
            PHASE_MEASURE: begin
                if (phase_ticks >= cfg_regs.settle_ticks) begin
                    if (hum < cfg_regs.dry_threshold) begin
                        if (retry_mark) begin
                            switch_phase(PHASE_ALARM);
                        end else begin
                            valve_q = 1'b1;
                            switch_phase(PHASE_WATER);
                        end
                    end else begin
                        alarm_q    = 1'b0;
                        retry_mark = 1'b0;
                        switch_phase(PHASE_WAIT);
                    end
                end
            end
            PHASE_WATER: begin
                if (hum >= cfg_regs.wet_threshold || phase_ticks >= cfg_regs.max_water_ticks) begin
                    valve_q    = 1'b0;
                    retry_mark = 1'b1;
                    switch_phase(PHASE_WAIT);
                end
            end
            default: begin
                // alarm acts at once and ignores humidity
                alarm_q    = 1'b1;
                retry_mark = 1'b0;
                switch_phase(PHASE_WAIT);
            end
        endcase
        res.valve_on = valve_q;
        res.alarm_on = alarm_q;
        res.phase    = phase_now;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg_regs.wait_ticks      = RST_WAIT_TICKS;
            cfg_regs.settle_ticks    = RST_SETTLE_TICKS;
            cfg_regs.max_water_ticks = RST_MAX_WATER;
            cfg_regs.dry_threshold   = RST_DRY_THRESH;
            cfg_regs.wet_threshold   = RST_WET_THRESH;
            phase_now   = PHASE_WAIT;
            phase_ticks = '0;
            retry_mark  = 1'b0;
            valve_q     = 1'b0;
            alarm_q     = 1'b0;
            expected_levels.delete();
        end else begin
            // Apply register writes; unknown indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WAIT_TICKS:   cfg_regs.wait_ticks      = i_cfg_data;
                    CFG_SETTLE_TICKS: cfg_regs.settle_ticks    = i_cfg_data;
                    CFG_MAX_WATER:    cfg_regs.max_water_ticks = i_cfg_data;
                    CFG_DRY_THRESH:   cfg_regs.dry_threshold   = i_cfg_data[HUM_W-1:0];
                    CFG_WET_THRESH:   cfg_regs.wet_threshold   = i_cfg_data[HUM_W-1:0];
                    default: ;
                endcase
            end
            // Compare results before queuing this edge's poll
            if (i_m_tvalid && i_m_tready) begin
                if (expected_levels.size() == 0) begin
                    $error("result item with nothing expected, tdata %h", i_m_tdata);
                    fails++;
                end else begin
                    want = expected_levels.pop_front();
                    check_field("valve_on", 32'(want.valve_on), 32'(i_m_tdata[0]));
                    check_field("alarm_on", 32'(want.alarm_on), 32'(i_m_tdata[1]));
                    check_field("phase", 32'(want.phase), 32'(i_m_tdata[3:2]));
                    check_field("tdata padding", 32'd0, 32'(i_m_tdata[7:4]));
                    checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_controller(i_s_tdata[0], i_s_tdata[7:1], want);
                expected_levels.push_back(want);
            end
        end
        o_pending    <= expected_levels.size();
        o_checked    <= checked;
        o_fail_count <= fails;
    end

endmodule

@@ bench/irrigation_sequencer_unit_tb.sv @@
`timescale 1ns / 1ps

// Drives polls and register writes into the irrigation sequencer under random
// bursts and output stalls; the checker beside it does all the comparing.
module irrigation_sequencer_unit_tb;
    import irseq_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT  = 2000;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [7:0]            m_tdata;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int chk_pending;
    int chk_checked;
    int chk_fails;

    // Sender and receiver bookkeeping
    int           burst_left   = 0;
    int           items_sent   = 0;
    int           settings_done = 0;
    logic [HUM_W-1:0] dry_now  = RST_DRY_THRESH;
    logic [HUM_W-1:0] wet_now  = RST_WET_THRESH;
    logic         hold_req     = 1'b0;
    logic         hold_done    = 1'b0;
    int           hold_left    = 0;
    int           seg_left     = 0;
    t_rx_mode     seg_mode     = RX_OPEN;
    int           idle_cycles  = 0;

    always #5 i_clk = ~i_clk;

    irrigation_sequencer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    irrigation_sequencer_unit_checker levels_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (chk_pending),
        .o_checked    (chk_checked),
        .o_fail_count (chk_fails)
    );

    // Stall the output on a pattern of its own, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_mode <= t_rx_mode'($urandom_range(0, 3));
                seg_left <= $urandom_range(4, 40);
            end else begin
                seg_left <= seg_left - 1;
            end
            case (seg_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:  m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ~m_tready;
            endcase
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("irrigation_sequencer_unit regression: fail");
            $finish;
        end
    end

    // Offer one poll, opening a random gap between bursts
    task automatic offer_item(input logic tick, input logic [HUM_W-1:0] hum);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 20);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) begin
                    s_tdata <= 8'($urandom());
                    @(posedge i_clk);
                end
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hum, tick};
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
        items_sent++;
    endtask

    // Hold one register write until taken; valid is lowered by the caller
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    // Drain every result, then rewrite all registers plus one unknown index
    task automatic apply_setting(input logic [TICK_W-1:0] wait_t, input logic [TICK_W-1:0] settle_t,
                                 input logic [TICK_W-1:0] water_t, input logic [HUM_W-1:0] dry,
                                 input logic [HUM_W-1:0] wet);
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (3) @(posedge i_clk);
        write_reg(CFG_WAIT_TICKS, wait_t);
        write_reg(CFG_SETTLE_TICKS, settle_t);
        write_reg(CFG_MAX_WATER, water_t);
        // upper data bits carry junk that the 7-bit registers must drop
        write_reg(CFG_DRY_THRESH, (32'($urandom()) & ~32'h7F) | 32'(dry));
        write_reg(CFG_WET_THRESH, (32'($urandom()) & ~32'h7F) | 32'(wet));
        write_reg(CFG_WET_THRESH + 3'($urandom_range(1, 3)), 32'($urandom()));
        cfg_valid <= 1'b0;
        dry_now   = dry;
        wet_now   = wet;
        burst_left = 0;
        settings_done++;
    endtask

    // Mostly dry or wet readings so that the phases keep cycling
    task automatic run_random(input int count);
        int               pick;
        logic [HUM_W-1:0] hum;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4 && dry_now != 0)
                hum = 7'($urandom_range(0, dry_now - 1));
            else if (pick < 8)
                hum = 7'($urandom_range(wet_now, 127));
            else
                hum = 7'($urandom_range(0, 127));
            offer_item($urandom_range(0, 3) != 0, hum);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default registers: field extremes, the controller stays in wait
        offer_item(1'b0, 7'd0);
        offer_item(1'b1, 7'd127);
        offer_item(1'b1, 7'd100);
        offer_item(1'b0, 7'd64);

        // Short times: walk through water, time-out, alarm and its clearing
        apply_setting(32'd1, 32'd1, 32'd3, 7'd30, 7'd60);
        offer_item(1'b1, 7'd50);   // to measure
        offer_item(1'b0, 7'd10);   // settling, no tick
        offer_item(1'b1, 7'd10);   // dry: open valve
        offer_item(1'b1, 7'd40);
        offer_item(1'b0, 7'd40);
        offer_item(1'b1, 7'd45);   // still watering, below the time-out
        offer_item(1'b1, 7'd20);   // watering times out
        offer_item(1'b1, 7'd20);   // to measure
        offer_item(1'b0, 7'd127);  // settling, no tick
        offer_item(1'b1, 7'd0);    // still dry after watering: alarm
        offer_item(1'b1, 7'd60);   // alarm acts and ignores the wet reading
        offer_item(1'b1, 7'd99);
        offer_item(1'b1, 7'd29);   // just below dry
        offer_item(1'b1, 7'd60);   // wet at the threshold stops watering
        offer_item(1'b1, 7'd5);
        offer_item(1'b1, 7'd30);   // at dry threshold counts as not dry

        // Zero times and thresholds
        apply_setting('0, '0, '0, 7'd0, 7'd0);
        run_random(40);

        // Largest times and thresholds
        apply_setting('1, '1, '1, 7'd127, 7'd127);
        run_random(20);

        // Long output stall while polls keep coming
        apply_setting(32'd2, 32'd1, 32'd4, 7'd30, 7'd60);
        hold_req <= 1'b1;
        run_random(100);

        apply_setting(32'd0, 32'd0, 32'd2, 7'd100, 7'd100);
        run_random(60);

        for (int k = 0; k < 4; k++) begin
            apply_setting($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4),
                          7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            run_random(70);
        end

        apply_setting(32'd1, 32'd0, 32'd1, 7'd127, 7'd0);
        run_random(40);

        // Drain and let the last results settle
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (5) @(posedge i_clk);

        $display("covered %0d polls over %0d register settings, one long output stall",
                 items_sent, settings_done + 1);
        $display("%0d result items compared on valve, alarm and phase", chk_checked);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("irrigation_sequencer_unit regression: pass");
        end else begin
            $display("irrigation_sequencer_unit regression: fail");
        end
        $finish;
    end

endmodule
